[hw/rtl/mcbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbs_pkg
// Types and constants shared by the mip chain byte size pipeline.
// ----------------------------------------------------------------------------
package mcbs_pkg;

  localparam int unsigned DIM_W   = 15;
  localparam int unsigned DEP_W   = 12;
  localparam int unsigned BPP_W   = 5;
  localparam int unsigned SLVL_W  = 4;
  localparam int unsigned LIM_W   = 5;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned PROD_W  = 2 * DIM_W;
  localparam int unsigned TERM_W  = PROD_W + DEP_W;
  localparam int unsigned SUM_W   = TERM_W + 1;
  localparam int unsigned TOT_W   = SUM_W + BPP_W;
  localparam int unsigned TOTAL_W = 44;
  localparam int unsigned WORD_W  = 32;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [DEP_W-1:0]   dep_t;
  typedef logic [BPP_W-1:0]   bpp_t;
  typedef logic [SLVL_W-1:0]  slvl_t;
  typedef logic [LIM_W-1:0]   lim_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [TERM_W-1:0]  term_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [TOT_W-1:0]   tot_t;
  typedef logic [TOTAL_W-1:0] total_t;

  typedef enum logic [1:0] {
    FMT_RAW   = 2'd0,
    FMT_BLK8  = 2'd1,
    FMT_BLK16 = 2'd2
  } fmt_e;

  localparam bpp_t BLK8_BYTES  = BPP_W'(8);
  localparam bpp_t BLK16_BYTES = BPP_W'(16);

  localparam tot_t TOTAL_MAX = {{(TOT_W-TOTAL_W){1'b0}}, {TOTAL_W{1'b1}}};
  localparam tot_t WORD_MAX  = {{(TOT_W-WORD_W){1'b0}}, {WORD_W{1'b1}}};

  typedef struct packed {
    dim_t  base_width;
    dim_t  base_height;
    dep_t  base_depth;
    bpp_t  bytes_per_pixel;
    slvl_t start_level;
    lim_t  level_limit;
    logic [1:0] format_class;
  } req_t;

  typedef struct packed {
    total_t total_bytes;
    logic   wide_flag;
    cnt_t   level_count;
  } res_t;

  // state carried from one mip level stage to the next
  typedef struct packed {
    dim_t  w;
    dim_t  h;
    dep_t  d;
    logic  run;
    lim_t  lim;
    fmt_e  fmt;
    bpp_t  scale;
    cnt_t  cnt;
    sum_t  sum;
    term_t term;
  } lvl_t;

endpackage

[hw/rtl/mcbs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbs_if
// Request and response channels of the mip chain byte size block.
// ----------------------------------------------------------------------------
interface mcbs_req_if;
  logic                 valid;
  logic                 ready;
  mcbs_pkg::dim_t       base_width;
  mcbs_pkg::dim_t       base_height;
  mcbs_pkg::dep_t       base_depth;
  mcbs_pkg::bpp_t       bytes_per_pixel;
  mcbs_pkg::slvl_t      start_level;
  mcbs_pkg::lim_t       level_limit;
  logic [1:0]           format_class;

  modport source (
    output valid, base_width, base_height, base_depth, bytes_per_pixel,
           start_level, level_limit, format_class,
    input  ready
  );
  modport sink (
    input  valid, base_width, base_height, base_depth, bytes_per_pixel,
           start_level, level_limit, format_class,
    output ready
  );
endinterface

interface mcbs_rsp_if;
  logic                 valid;
  logic                 ready;
  mcbs_pkg::total_t     total_bytes;
  logic                 wide_flag;
  mcbs_pkg::cnt_t       level_count;

  modport source (
    output valid, total_bytes, wide_flag, level_count,
    input  ready
  );
  modport sink (
    input  valid, total_bytes, wide_flag, level_count,
    output ready
  );
endinterface

[hw/rtl/mcbs_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbs_prep
// Two-stage front end: clamps and shifts the dimensions to the start level,
// picks the scale factor and finds the full level count.
// ----------------------------------------------------------------------------
module mcbs_prep #(
  parameter int unsigned MAX_DIM_LOG2 = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mcbs_pkg::req_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mcbs_pkg::lvl_t  out_o
);

  localparam int unsigned CMP_W   = mcbs_pkg::DIM_W + 2;
  localparam int unsigned DIM_TOP = 1 << MAX_DIM_LOG2;

  typedef struct packed {
    mcbs_pkg::dim_t  w;
    mcbs_pkg::dim_t  h;
    mcbs_pkg::dep_t  d;
    mcbs_pkg::lim_t  lim;
    mcbs_pkg::fmt_e  fmt;
    mcbs_pkg::bpp_t  scale;
    mcbs_pkg::dim_t  mx;
  } pre_t;

  pre_t s0_d, s0_q;
  logic s0_valid_q, s1_valid_q;
  logic s0_ready, s1_ready;
  mcbs_pkg::lvl_t s1_d, s1_q;

  mcbs_pkg::dim_t bw_c, bh_c, ws, hs;
  mcbs_pkg::dep_t bd_c, ds;
  mcbs_pkg::cnt_t cnt;

  assign s1_ready   = !s1_valid_q || out_ready_i;
  assign s0_ready   = !s0_valid_q || s1_ready;
  assign in_ready_o = s0_ready;

  // clamp, floor at one, shift to the start level
  always_comb begin
    bw_c = in_i.base_width;
    if (in_i.base_width == '0) begin
      bw_c = mcbs_pkg::DIM_W'(1);
    end else if (CMP_W'(in_i.base_width) > CMP_W'(DIM_TOP)) begin
      bw_c = mcbs_pkg::DIM_W'(DIM_TOP);
    end
    bh_c = in_i.base_height;
    if (in_i.base_height == '0) begin
      bh_c = mcbs_pkg::DIM_W'(1);
    end else if (CMP_W'(in_i.base_height) > CMP_W'(DIM_TOP)) begin
      bh_c = mcbs_pkg::DIM_W'(DIM_TOP);
    end
    bd_c = (in_i.base_depth == '0) ? mcbs_pkg::DEP_W'(1) : in_i.base_depth;

    ws = bw_c >> in_i.start_level;
    hs = bh_c >> in_i.start_level;
    ds = bd_c >> in_i.start_level;

    s0_d.w   = (ws == '0) ? mcbs_pkg::DIM_W'(1) : ws;
    s0_d.h   = (hs == '0) ? mcbs_pkg::DIM_W'(1) : hs;
    s0_d.d   = (ds == '0) ? mcbs_pkg::DEP_W'(1) : ds;
    s0_d.lim = in_i.level_limit;
    s0_d.fmt = mcbs_pkg::fmt_e'(in_i.format_class);
    s0_d.mx  = (bw_c > bh_c) ? bw_c : bh_c;
    case (in_i.format_class)
      mcbs_pkg::FMT_RAW:  s0_d.scale = in_i.bytes_per_pixel;
      mcbs_pkg::FMT_BLK8: s0_d.scale = mcbs_pkg::BLK8_BYTES;
      default:            s0_d.scale = mcbs_pkg::BLK16_BYTES;
    endcase
  end

  // level count is one past the top set bit of the larger side
  always_comb begin
    cnt = mcbs_pkg::CNT_W'(1);
    for (int i = 0; i < int'(mcbs_pkg::DIM_W); i++) begin
      if (s0_q.mx[i]) begin
        cnt = mcbs_pkg::CNT_W'(i + 1);
      end
    end
    s1_d.w     = s0_q.w;
    s1_d.h     = s0_q.h;
    s1_d.d     = s0_q.d;
    s1_d.run   = 1'b1;
    s1_d.lim   = s0_q.lim;
    s1_d.fmt   = s0_q.fmt;
    s1_d.scale = s0_q.scale;
    s1_d.cnt   = cnt;
    s1_d.sum   = '0;
    s1_d.term  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= in_valid_i;
      end
      if (s1_ready) begin
        s1_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      s0_q <= s0_d;
    end
    if (s1_ready && s0_valid_q) begin
      s1_q <= s1_d;
    end
  end

  assign out_valid_o = s1_valid_q;
  assign out_o       = s1_q;

endmodule

[hw/rtl/mcbs_level.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbs_level
// One mip level: area multiply, then depth multiply, while the previous
// level's term is folded into the running sum.
// ----------------------------------------------------------------------------
module mcbs_level #(
  parameter int unsigned LEVEL = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mcbs_pkg::lvl_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mcbs_pkg::lvl_t  out_o
);

  localparam int unsigned DIMP_W = mcbs_pkg::DIM_W + 1;

  logic a_valid_q, b_valid_q;
  logic a_ready, b_ready;
  logic act;
  logic [DIMP_W-1:0] wp3, hp3;
  mcbs_pkg::dim_t ea, eb;
  mcbs_pkg::lvl_t a_d, a_q, b_d, b_q;
  mcbs_pkg::prod_t p_d, p_q;
  mcbs_pkg::dep_t pd_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    act = in_i.run && (mcbs_pkg::LIM_W'(LEVEL) < in_i.lim);
    wp3 = DIMP_W'(in_i.w) + DIMP_W'(3);
    hp3 = DIMP_W'(in_i.h) + DIMP_W'(3);
    if (in_i.fmt == mcbs_pkg::FMT_RAW) begin
      ea = in_i.w;
      eb = in_i.h;
    end else begin
      // 4x4 block counts
      ea = mcbs_pkg::DIM_W'(wp3 >> 2);
      eb = mcbs_pkg::DIM_W'(hp3 >> 2);
    end
    p_d = act ? mcbs_pkg::PROD_W'(ea) * mcbs_pkg::PROD_W'(eb) : '0;

    a_d      = in_i;
    a_d.sum  = in_i.sum + mcbs_pkg::SUM_W'(in_i.term);
    a_d.term = '0;
    a_d.w    = (in_i.w > mcbs_pkg::DIM_W'(1)) ? (in_i.w >> 1) : in_i.w;
    a_d.h    = (in_i.h > mcbs_pkg::DIM_W'(1)) ? (in_i.h >> 1) : in_i.h;
    a_d.d    = (in_i.d > mcbs_pkg::DEP_W'(1)) ? (in_i.d >> 1) : in_i.d;
    a_d.run  = act && !(in_i.w == mcbs_pkg::DIM_W'(1) && in_i.h == mcbs_pkg::DIM_W'(1));
  end

  always_comb begin
    b_d      = a_q;
    b_d.term = mcbs_pkg::TERM_W'(p_q) * mcbs_pkg::TERM_W'(pd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_q  <= a_d;
      p_q  <= p_d;
      pd_q <= in_i.d;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;

endmodule

[hw/rtl/mcbs_total.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbs_total
// Back end: adds the last term, scales by bytes per pixel or per block,
// then saturates and flags totals beyond 32 bits.
// ----------------------------------------------------------------------------
module mcbs_total (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mcbs_pkg::lvl_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mcbs_pkg::res_t  out_o
);

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;
  mcbs_pkg::sum_t sum_q;
  mcbs_pkg::bpp_t scale_q;
  mcbs_pkg::cnt_t cnt1_q, cnt2_q;
  mcbs_pkg::tot_t tot_d, tot_q;
  mcbs_pkg::res_t res_d, res_q;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    tot_d = mcbs_pkg::TOT_W'(sum_q) * mcbs_pkg::TOT_W'(scale_q);
    res_d.total_bytes = (tot_q > mcbs_pkg::TOTAL_MAX) ? '1 : tot_q[mcbs_pkg::TOTAL_W-1:0];
    res_d.wide_flag   = tot_q > mcbs_pkg::WORD_MAX;
    res_d.level_count = cnt2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      sum_q   <= in_i.sum + mcbs_pkg::SUM_W'(in_i.term);
      scale_q <= in_i.scale;
      cnt1_q  <= in_i.cnt;
    end
    if (s2_ready && s1_valid_q) begin
      tot_q  <= tot_d;
      cnt2_q <= cnt1_q;
    end
    if (s3_ready && s2_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_o       = res_q;

endmodule

[hw/rtl/mip_chain_byte_size.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_chain_byte_size
// Total byte size of a run of mip levels, raw or block compressed, and the
// full level count of the base image.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle while the response side
// takes responses. A request passes through 2 * NLEV + 5 register stages,
// where NLEV is MAX_DIM_LOG2 + 1 capped at 15. The depth is set by the level
// chain, which has one pair of multiply stages per possible mip level. The
// chain sits between a two-stage front end and a three-stage scale and
// saturate back end. Bubbles close up under back pressure, so requests keep
// flowing while a response waits to be taken, until every stage is full.
module mip_chain_byte_size #(
  parameter int unsigned MAX_DIM_LOG2 = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mcbs_req_if.sink          req_i,
  mcbs_rsp_if.source        rsp_o
);

  localparam int unsigned NLEV = (MAX_DIM_LOG2 + 1 < mcbs_pkg::DIM_W) ?
                                 MAX_DIM_LOG2 + 1 : mcbs_pkg::DIM_W;

  mcbs_pkg::req_t req;
  mcbs_pkg::res_t res;
  mcbs_pkg::lvl_t chain [NLEV+1];
  logic chain_valid [NLEV+1];
  logic chain_ready [NLEV+1];

  assign req.base_width      = req_i.base_width;
  assign req.base_height     = req_i.base_height;
  assign req.base_depth      = req_i.base_depth;
  assign req.bytes_per_pixel = req_i.bytes_per_pixel;
  assign req.start_level     = req_i.start_level;
  assign req.level_limit     = req_i.level_limit;
  assign req.format_class    = req_i.format_class;

  mcbs_prep #(
    .MAX_DIM_LOG2 (MAX_DIM_LOG2)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_i        (req),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_o       (chain[0])
  );

  for (genvar k = 0; k < NLEV; k++) begin : g_level
    mcbs_level #(
      .LEVEL (k)
    ) u_level (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_i        (chain[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_o       (chain[k+1])
    );
  end

  mcbs_total u_total (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[NLEV]),
    .in_ready_o  (chain_ready[NLEV]),
    .in_i        (chain[NLEV]),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_o       (res)
  );

  assign rsp_o.total_bytes = res.total_bytes;
  assign rsp_o.wide_flag   = res.wide_flag;
  assign rsp_o.level_count = res.level_count;

endmodule

[test/mcbs_size_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcbs_size_checker
// Watches the request and response channels of the mip chain byte size block.
// Every accepted request is turned into the expected total, wide flag and
// level count. Each accepted response is compared field by field with the
// oldest waiting expectation.
// ----------------------------------------------------------------------------
module mcbs_size_checker #(
  parameter int unsigned MAX_DIM_LOG2 = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcbs_req_if         req_i,
  mcbs_rsp_if         rsp_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import mcbs_pkg::*;

  localparam longint unsigned DIM_TOP   = 64'd1 << MAX_DIM_LOG2;
  localparam longint unsigned TOTAL_TOP = (64'd1 << TOTAL_W) - 64'd1;
  localparam longint unsigned WORD_TOP  = 64'hFFFF_FFFF;

  res_t size_expect_q[$];
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  function automatic res_t predict_chain_size(req_t q);
    longint unsigned bw, bh, bd, w, h, d, sum, total;
    int unsigned n, cnt;
    res_t r;
    bw = q.base_width;
    bh = q.base_height;
    bd = q.base_depth;
    if (bw == 0) bw = 1;
    if (bw > DIM_TOP) bw = DIM_TOP;
    if (bh == 0) bh = 1;
    if (bh > DIM_TOP) bh = DIM_TOP;
    if (bd == 0) bd = 1;

    w = bw >> q.start_level;
    h = bh >> q.start_level;
    d = bd >> q.start_level;
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    if (d == 0) d = 1;
    w = w << 1;
    h = h << 1;
    d = d << 1;
    sum = 0;
    n = 0;
    while (n < q.level_limit && (w != 1 || h != 1)) begin
      if (w > 1) w = w >> 1;
      if (h > 1) h = h >> 1;
      if (d > 1) d = d >> 1;
      if (q.format_class == FMT_RAW)
        sum += w * h * d;
      else
        sum += ((w + 3) >> 2) * ((h + 3) >> 2) * d;
      n++;
    end

    if (q.format_class == FMT_RAW)
      total = sum * q.bytes_per_pixel;
    else if (q.format_class == FMT_BLK8)
      total = sum * 8;
    else
      total = sum * 16;

    // level count of the clamped base image
    w = bw;
    h = bh;
    cnt = 1;
    while (w > 1 || h > 1) begin
      if (w > 1) w = w >> 1;
      if (h > 1) h = h >> 1;
      cnt++;
    end

    r.total_bytes = (total > TOTAL_TOP) ? total_t'(TOTAL_TOP) : total_t'(total);
    r.wide_flag   = (total > WORD_TOP);
    r.level_count = cnt_t'(cnt);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    req_t q;
    res_t exp_r;
    if (!rst_ni) begin
      size_expect_q.delete();
      mismatch_cnt = 0;
      pending_cnt  = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        q.base_width      = req_i.base_width;
        q.base_height     = req_i.base_height;
        q.base_depth      = req_i.base_depth;
        q.bytes_per_pixel = req_i.bytes_per_pixel;
        q.start_level     = req_i.start_level;
        q.level_limit     = req_i.level_limit;
        q.format_class    = req_i.format_class;
        size_expect_q.push_back(predict_chain_size(q));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (size_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: response with no request waiting: total %0h wide %0b cnt %0d",
                     $realtime, rsp_i.total_bytes, rsp_i.wide_flag, rsp_i.level_count);
        end else begin
          exp_r = size_expect_q.pop_front();
          if (rsp_i.total_bytes !== exp_r.total_bytes ||
              rsp_i.wide_flag !== exp_r.wide_flag ||
              rsp_i.level_count !== exp_r.level_count) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: mismatch total exp %0h got %0h,", $realtime,
                       exp_r.total_bytes, rsp_i.total_bytes,
                       " wide exp %0b got %0b,", exp_r.wide_flag, rsp_i.wide_flag,
                       " cnt exp %0d got %0d", exp_r.level_count, rsp_i.level_count);
          end
        end
      end
      pending_cnt = size_expect_q.size();
    end
  end

  assign pending_o    = pending_cnt;
  assign fail_count_o = mismatch_cnt;

endmodule

[test/tb_mip_chain_byte_size.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mip_chain_byte_size
// Drives size requests into the mip chain byte size block: a directed set of
// corner requests, then random requests with random gaps on both channels and
// one long response hold-off that backs the pipeline up. The checker beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_mip_chain_byte_size;
  import mcbs_pkg::*;

  localparam int unsigned MAX_DIM_LOG2 = 14;
  localparam int unsigned PIPE_CYCLES  = 2 * (MAX_DIM_LOG2 + 1) + 5;
  localparam int unsigned RAND_REQS    = 1130;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam logic [1:0]  FMT_RSVD     = 2'd3;

  logic clk_i;
  logic rst_ni;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned reqs_sent;
  bit tx_calm;
  bit rx_calm;

  mcbs_req_if req_if ();
  mcbs_rsp_if rsp_if ();

  mip_chain_byte_size #(
    .MAX_DIM_LOG2(MAX_DIM_LOG2)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  mcbs_size_checker #(
    .MAX_DIM_LOG2(MAX_DIM_LOG2)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_idle(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t mk_query(int unsigned w, int unsigned h, int unsigned d,
                                    int unsigned bpp, int unsigned slvl,
                                    int unsigned lim, logic [1:0] fmt);
    req_t q;
    q.base_width      = dim_t'(w);
    q.base_height     = dim_t'(h);
    q.base_depth      = dep_t'(d);
    q.bytes_per_pixel = bpp_t'(bpp);
    q.start_level     = slvl_t'(slvl);
    q.level_limit     = lim_t'(lim);
    q.format_class    = fmt;
    return q;
  endfunction

  function automatic req_t random_query();
    req_t q;
    logic [63:0] raw;
    // some requests with every bit random, the rest inside the legal ranges
    if ($urandom_range(0, 9) < 2) begin
      raw = {$urandom, $urandom};
      q = raw[$bits(req_t)-1:0];
    end else begin
      q.base_width      = dim_t'($urandom_range(1, 1 << $urandom_range(0, 14)));
      q.base_height     = dim_t'($urandom_range(1, 1 << $urandom_range(0, 14)));
      if ($urandom_range(0, 1) == 0)
        q.base_depth    = dep_t'(1);
      else
        q.base_depth    = dep_t'($urandom_range(1, 1 << $urandom_range(0, 11)));
      q.bytes_per_pixel = bpp_t'($urandom_range(1, 16));
      q.start_level     = slvl_t'($urandom_range(0, $urandom_range(0, 15)));
      q.level_limit     = lim_t'($urandom_range(0, 16));
      q.format_class    = 2'($urandom_range(0, 2));
    end
    return q;
  endfunction

  task automatic push_query(input req_t q);
    int unsigned gap;
    req_if.valid           <= 1'b1;
    req_if.base_width      <= q.base_width;
    req_if.base_height     <= q.base_height;
    req_if.base_depth      <= q.base_depth;
    req_if.bytes_per_pixel <= q.bytes_per_pixel;
    req_if.start_level     <= q.start_level;
    req_if.level_limit     <= q.level_limit;
    req_if.format_class    <= q.format_class;
    do @(posedge clk_i); while (!req_if.ready);
    reqs_sent++;
    gap = pick_idle(tx_calm);
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // response side: random stalls plus one long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned cyc;
    bit held_off;
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    cyc          = 0;
    held_off     = 1'b0;
    rx_calm      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 128 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (!held_off && reqs_sent >= 200) begin
        held_off = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = pick_idle(rx_calm);
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  initial begin
    req_if.valid           = 1'b0;
    req_if.base_width      = '0;
    req_if.base_height     = '0;
    req_if.base_depth      = '0;
    req_if.bytes_per_pixel = '0;
    req_if.start_level     = '0;
    req_if.level_limit     = '0;
    req_if.format_class    = '0;
    reqs_sent = 0;
    tx_calm   = 1'b1;
    rst_ni    = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corners: tiny, full size, wide and saturating totals, clamps, formats
    push_query(mk_query(1, 1, 1, 1, 0, 16, FMT_RAW));
    push_query(mk_query(16384, 16384, 1, 16, 0, 16, FMT_RAW));
    push_query(mk_query(16384, 16384, 2048, 16, 0, 16, FMT_RAW));
    push_query(mk_query(16384, 16384, 4095, 31, 0, 16, FMT_RAW));
    push_query(mk_query(0, 0, 0, 4, 0, 16, FMT_RAW));
    push_query(mk_query(32767, 32767, 1, 4, 0, 16, FMT_RAW));
    push_query(mk_query(20000, 3, 1, 4, 2, 16, FMT_RAW));
    push_query(mk_query(640, 480, 1, 4, 0, 0, FMT_RAW));
    push_query(mk_query(640, 480, 1, 4, 0, 31, FMT_RAW));
    push_query(mk_query(1000, 300, 1, 0, 0, 16, FMT_BLK8));
    push_query(mk_query(1000, 300, 1, 0, 0, 16, FMT_BLK16));
    push_query(mk_query(1000, 300, 1, 0, 0, 16, FMT_RSVD));
    push_query(mk_query(16384, 1, 1, 1, 0, 16, FMT_RAW));
    push_query(mk_query(1, 16384, 1, 1, 0, 16, FMT_BLK8));
    push_query(mk_query(256, 256, 256, 4, 0, 16, FMT_RAW));
    push_query(mk_query(16384, 16384, 2048, 0, 15, 16, FMT_RAW));
    push_query(mk_query(300, 200, 64, 31, 3, 5, FMT_BLK16));
    push_query(mk_query(7, 5, 3, 3, 1, 1, FMT_BLK8));
    push_query(mk_query(16384, 16384, 2048, 16, 0, 16, FMT_BLK16));
    push_query(mk_query(4096, 4096, 1, 4, 12, 16, FMT_RAW));
    push_query(mk_query(5, 9, 0, 2, 14, 2, FMT_RAW));
    push_query(mk_query(32767, 1, 4095, 31, 0, 31, FMT_RAW));

    for (int unsigned i = 0; i < RAND_REQS; i++) begin
      if (i % 64 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      push_query(random_query());
    end
    req_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (PIPE_CYCLES + 10) @(negedge clk_i);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mcbs_pkg.sv
hw/rtl/mcbs_if.sv
hw/rtl/mcbs_prep.sv
hw/rtl/mcbs_level.sv
hw/rtl/mcbs_total.sv
hw/rtl/mip_chain_byte_size.sv
test/mcbs_size_checker.sv
test/tb_mip_chain_byte_size.sv
